@@ hw/rtl/v3alu_pkg.sv @@
// shared constants, types and helpers for the 3d vector alu
`timescale 1ns / 1ps
`default_nettype none
package v3alu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // operand of a multiplier: word plus one bit for the distance differences
  localparam int OP_BITS   = WORD_BITS + 1;
  localparam int PROD_BITS = 2 * OP_BITS;
  localparam int EXT_BITS  = PROD_BITS + 1;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DD_BITS   = ROOT_BITS + FRAC_BITS;

  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_SUB   = 3'd1;
  localparam logic [2:0] MODE_MUL   = 3'd2;
  localparam logic [2:0] MODE_SCALE = 3'd3;
  localparam logic [2:0] MODE_NORM  = 3'd4;
  localparam logic [2:0] MODE_CROSS = 3'd5;
  localparam logic [2:0] MODE_LEN   = 3'd6;
  localparam logic [2:0] MODE_DIST  = 3'd7;

  // data that rides along with an item through the root and divide cells
  typedef struct packed {
    logic [2:0]                mode;
    logic                      ov;
    logic [2:0]                neg;
    logic [2:0][WORD_BITS-1:0] vec;
    logic [WORD_BITS-1:0]      mag;
  } side_t;

  typedef struct packed {
    logic                 valid;
    side_t                side;
    logic [SUM_BITS-1:0]  s;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                     valid;
    side_t                    side;
    logic                     lzero;
    logic [DD_BITS-1:0]       dd;
    logic [2:0][NUM_BITS-1:0] rem;
    logic [2:0][Q_BITS-1:0]   q;
  } div_t;

  typedef struct packed {
    logic                 ov;
    logic [WORD_BITS-1:0] val;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [EXT_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] smax;
    logic signed [EXT_BITS-1:0] smin;
    sat_t r;
    smax = {{(EXT_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    smin = {{(EXT_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
    if (v > smax) begin
      r.ov  = 1'b1;
      r.val = smax[WORD_BITS-1:0];
    end else if (v < smin) begin
      r.ov  = 1'b1;
      r.val = smin[WORD_BITS-1:0];
    end else begin
      r.ov  = 1'b0;
      r.val = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/v3alu_front.sv @@
// front pipeline: operand select, products, sums and word saturation
`timescale 1ns / 1ps
`default_nettype none
module v3alu_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic [2:0]                          mode,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] a_x,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] a_y,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] a_z,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] b_x,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] b_y,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] b_z,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] factor,
  output v3alu_pkg::sqrt_t                         sq_out
);

  localparam int W  = v3alu_pkg::WORD_BITS;
  localparam int OB = v3alu_pkg::OP_BITS;
  localparam int PB = v3alu_pkg::PROD_BITS;
  localparam int EB = v3alu_pkg::EXT_BITS;
  localparam int SB = v3alu_pkg::SUM_BITS;
  localparam int F  = v3alu_pkg::FRAC_BITS;

  logic signed [W-1:0]  av [3];
  logic signed [W-1:0]  bv [3];
  logic signed [OB-1:0] ae [3];
  logic signed [OB-1:0] be [3];
  logic signed [OB-1:0] fe;
  logic signed [OB-1:0] dv [3];
  logic signed [OB-1:0] as_next [3];
  logic signed [OB-1:0] opx_next [6];
  logic signed [OB-1:0] opy_next [6];

  // stage 1 registers
  logic              v1;
  logic [2:0]        mode1;
  logic signed [OB-1:0] opx1 [6];
  logic signed [OB-1:0] opy1 [6];
  logic signed [W-1:0]  a1 [3];
  logic signed [OB-1:0] as1 [3];

  // stage 2 registers
  logic              v2;
  logic [2:0]        mode2;
  logic signed [PB-1:0] p2 [6];
  logic signed [W-1:0]  a2 [3];
  logic signed [OB-1:0] as2 [3];

  // stage 3 registers
  logic              v3;
  logic [2:0]        mode3;
  logic signed [EB-1:0] v3c [3];
  logic [SB-1:0]     sum3;
  logic signed [W-1:0]  a3 [3];
  logic signed [OB-1:0] as3 [3];

  logic signed [EB-1:0] vc_next [3];
  logic [SB-1:0]     sum_next;
  v3alu_pkg::sqrt_t  sq_next;

  assign av[0] = a_x;
  assign av[1] = a_y;
  assign av[2] = a_z;
  assign bv[0] = b_x;
  assign bv[1] = b_y;
  assign bv[2] = b_z;
  assign fe    = OB'(factor);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ae[i] = OB'(av[i]);
      be[i] = OB'(bv[i]);
      dv[i] = be[i] - ae[i];
      as_next[i] = (mode == v3alu_pkg::MODE_SUB) ? ae[i] - be[i] : ae[i] + be[i];
    end
    for (int j = 0; j < 6; j++) begin
      opx_next[j] = '0;
      opy_next[j] = '0;
    end
    unique case (mode)
      v3alu_pkg::MODE_MUL: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = ae[i];
          opy_next[i] = be[i];
        end
      end
      v3alu_pkg::MODE_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = ae[i];
          opy_next[i] = fe;
        end
      end
      v3alu_pkg::MODE_CROSS: begin
        opx_next[0] = ae[1]; opy_next[0] = be[2];
        opx_next[3] = ae[2]; opy_next[3] = be[1];
        opx_next[1] = ae[2]; opy_next[1] = be[0];
        opx_next[4] = ae[0]; opy_next[4] = be[2];
        opx_next[2] = ae[0]; opy_next[2] = be[1];
        opx_next[5] = ae[1]; opy_next[5] = be[0];
      end
      v3alu_pkg::MODE_NORM, v3alu_pkg::MODE_LEN: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = ae[i];
          opy_next[i] = ae[i];
        end
      end
      v3alu_pkg::MODE_DIST: begin
        for (int i = 0; i < 3; i++) begin
          opx_next[i] = dv[i];
          opy_next[i] = dv[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1    <= in_valid;
      mode1 <= mode;
      for (int j = 0; j < 6; j++) begin
        opx1[j] <= opx_next[j];
        opy1[j] <= opy_next[j];
      end
      for (int i = 0; i < 3; i++) begin
        a1[i]  <= av[i];
        as1[i] <= as_next[i];
      end

      v2    <= v1;
      mode2 <= mode1;
      for (int j = 0; j < 6; j++) begin
        p2[j] <= opx1[j] * opy1[j];
      end
      for (int i = 0; i < 3; i++) begin
        a2[i]  <= a1[i];
        as2[i] <= as1[i];
      end

      v3    <= v2;
      mode3 <= mode2;
      sum3  <= sum_next;
      for (int i = 0; i < 3; i++) begin
        v3c[i] <= vc_next[i];
        a3[i]  <= a2[i];
        as3[i] <= as2[i];
      end

      sq_out <= sq_next;
    end
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      sq_out.valid <= 1'b0;
    end
  end

  // cross takes the exact difference of its two products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mode2 == v3alu_pkg::MODE_CROSS) begin
        vc_next[i] = EB'(p2[i]) - EB'(p2[i+3]);
      end else begin
        vc_next[i] = EB'(p2[i]);
      end
    end
    // squares are never negative here, so the sum is taken unsigned
    sum_next = SB'(unsigned'(p2[0])) + SB'(unsigned'(p2[1])) + SB'(unsigned'(p2[2]));
  end

  logic signed [EB-1:0] rnd [3];
  logic signed [EB-1:0] shv [3];
  logic signed [W:0]    nega [3];
  v3alu_pkg::sat_t      st [3];

  always_comb begin
    sq_next       = '0;
    sq_next.valid = v3;
    sq_next.side.mode = mode3;
    sq_next.s     = sum3;
    for (int i = 0; i < 3; i++) begin
      // round toward zero: bias negative values before the arithmetic shift
      rnd[i]  = v3c[i] + (v3c[i][EB-1] ? EB'((1 << F) - 1) : EB'(0));
      shv[i]  = rnd[i] >>> F;
      nega[i] = -(W+1)'(a3[i]);
      if (mode3 == v3alu_pkg::MODE_ADD || mode3 == v3alu_pkg::MODE_SUB) begin
        st[i] = v3alu_pkg::sat_word(EB'(as3[i]));
      end else begin
        st[i] = v3alu_pkg::sat_word(shv[i]);
      end
      unique case (mode3)
        v3alu_pkg::MODE_NORM: begin
          sq_next.side.neg[i] = a3[i][W-1];
          sq_next.side.vec[i] = a3[i][W-1] ? nega[i][W-1:0] : a3[i];
        end
        v3alu_pkg::MODE_LEN, v3alu_pkg::MODE_DIST: begin
          sq_next.side.vec[i] = '0;
        end
        default: begin
          sq_next.side.vec[i] = st[i].val;
          if (st[i].ov) begin
            sq_next.side.ov = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/v3alu_sqrt_cell.sv @@
// one cell of the square root chain: settles one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module v3alu_sqrt_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire v3alu_pkg::sqrt_t d_in,
  output v3alu_pkg::sqrt_t      d_out
);

  localparam int SB = v3alu_pkg::SUM_BITS;
  localparam int RB = v3alu_pkg::REM_BITS;
  localparam int TB = v3alu_pkg::ROOT_BITS;

  logic [RB+1:0]     rem_sh;
  logic [RB+1:0]     trial;
  v3alu_pkg::sqrt_t  nxt;

  always_comb begin
    nxt    = d_in;
    rem_sh = {d_in.rem, d_in.s[SB-1:SB-2]};
    trial  = (RB+2)'({d_in.root, 2'b01});
    nxt.s  = {d_in.s[SB-3:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = RB'(rem_sh - trial);
      nxt.root = {d_in.root[TB-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh[RB-1:0];
      nxt.root = {d_in.root[TB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
    if (rst) begin
      d_out.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/v3alu_div_cell.sv @@
// one cell of the divide chain: one quotient bit for each of three lanes
`timescale 1ns / 1ps
`default_nettype none
module v3alu_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire v3alu_pkg::div_t d_in,
  output v3alu_pkg::div_t      d_out
);

  localparam int NB = v3alu_pkg::NUM_BITS;
  localparam int DB = v3alu_pkg::DD_BITS;
  localparam int QB = v3alu_pkg::Q_BITS;

  logic [DB-1:0]    rem_ext [3];
  v3alu_pkg::div_t  nxt;

  always_comb begin
    nxt    = d_in;
    nxt.dd = d_in.dd >> 1;
    for (int i = 0; i < 3; i++) begin
      rem_ext[i] = DB'(d_in.rem[i]);
      if (rem_ext[i] >= d_in.dd) begin
        nxt.rem[i] = NB'(rem_ext[i] - d_in.dd);
        nxt.q[i]   = {d_in.q[i][QB-2:0], 1'b1};
      end else begin
        nxt.q[i]   = {d_in.q[i][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
    if (rst) begin
      d_out.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/vector3_alu.sv @@
// every mode takes the same path from an accepted transaction to out_valid
// throughput: one transaction per cycle; the chain stalls as a whole while a result waits
// the depth is set by the 34 root cells and the 17 divide cells behind the 4 front stages
// reset clears the valid bits of every stage and the output register; no other state
`timescale 1ns / 1ps
`default_nettype none
module vector3_alu (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [2:0]                             mode,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] a_x,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] a_y,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] a_z,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] b_x,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] b_y,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] b_z,
  input  wire logic signed [v3alu_pkg::WORD_BITS-1:0] factor,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [v3alu_pkg::WORD_BITS-1:0]      r_x,
  output logic signed [v3alu_pkg::WORD_BITS-1:0]      r_y,
  output logic signed [v3alu_pkg::WORD_BITS-1:0]      r_z,
  output logic [v3alu_pkg::WORD_BITS-1:0]             magnitude,
  output logic                                        overflow
);

  localparam int W  = v3alu_pkg::WORD_BITS;
  localparam int F  = v3alu_pkg::FRAC_BITS;
  localparam int TB = v3alu_pkg::ROOT_BITS;
  localparam int QB = v3alu_pkg::Q_BITS;

  logic en;
  v3alu_pkg::sqrt_t sq [TB+1];
  v3alu_pkg::div_t  dv [QB+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  v3alu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .mode     (mode),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .factor   (factor),
    .sq_out   (sq[0])
  );

  for (genvar k = 0; k < TB; k++) begin : g_sqrt
    v3alu_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (sq[k]),
      .d_out (sq[k+1])
    );
  end

  // root is final here: saturate magnitude and set up the divide lanes
  always_comb begin
    dv[0]       = '0;
    dv[0].valid = sq[TB].valid;
    dv[0].side  = sq[TB].side;
    dv[0].lzero = (sq[TB].root == '0);
    dv[0].dd    = {sq[TB].root, {F{1'b0}}};
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] = {sq[TB].side.vec[i], {F{1'b0}}};
    end
    if (sq[TB].side.mode == v3alu_pkg::MODE_LEN || sq[TB].side.mode == v3alu_pkg::MODE_DIST)
    begin
      if (sq[TB].root[TB-1:W] != '0) begin
        dv[0].side.mag = '1;
        dv[0].side.ov  = 1'b1;
      end else begin
        dv[0].side.mag = sq[TB].root[W-1:0];
      end
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    v3alu_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (dv[k]),
      .d_out (dv[k+1])
    );
  end

  logic [W-1:0] qw [3];
  logic [W-1:0] rv_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qw[i] = W'(dv[QB].q[i]);
      if (dv[QB].side.mode == v3alu_pkg::MODE_NORM) begin
        // zero length vector normalizes to zero
        if (dv[QB].lzero) begin
          rv_next[i] = '0;
        end else begin
          rv_next[i] = dv[QB].side.neg[i] ? -qw[i] : qw[i];
        end
      end else begin
        rv_next[i] = dv[QB].side.vec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_valid <= dv[QB].valid;
      r_x       <= rv_next[0];
      r_y       <= rv_next[1];
      r_z       <= rv_next[2];
      magnitude <= dv[QB].side.mag;
      overflow  <= dv[QB].side.ov;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ tb/vector3_alu_checker.sv @@
// checker for the 3d vector alu: predicts each result and compares it with the output channel
`timescale 1ns / 1ps
module vector3_alu_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [31:0] a_x,
  input  wire logic [31:0] a_y,
  input  wire logic [31:0] a_z,
  input  wire logic [31:0] b_x,
  input  wire logic [31:0] b_y,
  input  wire logic [31:0] b_z,
  input  wire logic [31:0] factor,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] r_x,
  input  wire logic [31:0] r_y,
  input  wire logic [31:0] r_z,
  input  wire logic [31:0] magnitude,
  input  wire logic        overflow,
  output int               fail_count,
  output int               pending
);
  import v3alu_pkg::*;

  typedef struct {
    logic [31:0] rx, ry, rz, mag;
    logic        ov;
  } vec_result_t;

  vec_result_t expected_q[$];

  assign pending = expected_q.size();

  // saturate an exact signed value to a signed word
  function automatic logic [31:0] clamp_signed(input logic signed [131:0] v,
                                               inout logic ov);
    if (v > 132'sh7fffffff) begin
      ov = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -132'sh80000000) begin
      ov = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // truncating shift of a product toward zero
  function automatic logic signed [131:0] drop_frac(input logic signed [131:0] v);
    logic signed [131:0] m;
    m = v < 0 ? -v : v;
    m = m >>> FRAC_BITS;
    return v < 0 ? -m : m;
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [131:0] s);
    logic [131:0] root, cand;
    root = 0;
    for (int bit_i = 65; bit_i >= 0; bit_i--) begin
      cand = root | (132'd1 << bit_i);
      if (cand * cand <= s) root = cand;
    end
    return root[127:0];
  endfunction

  function automatic vec_result_t predict_alu(input logic [2:0] op,
      input logic signed [31:0] ax, ay, az, bx, by, bz, f);
    vec_result_t res;
    logic signed [131:0] a [3];
    logic signed [131:0] b [3];
    logic signed [131:0] v;
    logic [131:0] s;
    logic [127:0] len;
    res = '{default: '0};
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    case (op)
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_SCALE, MODE_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          case (op)
            MODE_ADD:   v = a[i] + b[i];
            MODE_SUB:   v = a[i] - b[i];
            MODE_MUL:   v = drop_frac(a[i] * b[i]);
            MODE_SCALE: v = drop_frac(a[i] * 132'(signed'(f)));
            default:    v = drop_frac(a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3]);
          endcase
          case (i)
            0: res.rx = clamp_signed(v, res.ov);
            1: res.ry = clamp_signed(v, res.ov);
            default: res.rz = clamp_signed(v, res.ov);
          endcase
        end
      end
      MODE_NORM: begin
        s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        len = floor_sqrt(s);
        if (len != 0) begin
          for (int i = 0; i < 3; i++) begin
            v = a[i] < 0 ? -a[i] : a[i];
            v = (v <<< FRAC_BITS) / 132'(len);
            if (a[i] < 0) v = -v;
            case (i)
              0: res.rx = clamp_signed(v, res.ov);
              1: res.ry = clamp_signed(v, res.ov);
              default: res.rz = clamp_signed(v, res.ov);
            endcase
          end
        end
      end
      default: begin
        if (op == MODE_DIST) for (int i = 0; i < 3; i++) a[i] = b[i] - a[i];
        len = floor_sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
        if (len > 128'hffffffff) begin
          res.ov = 1'b1;
          res.mag = 32'hffffffff;
        end else begin
          res.mag = len[31:0];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    vec_result_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(predict_alu(mode, a_x, a_y, a_z, b_x, b_y, b_z, factor));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (r_x !== e.rx) $error("r_x expected %h actual %h", e.rx, r_x);
          if (r_y !== e.ry) $error("r_y expected %h actual %h", e.ry, r_y);
          if (r_z !== e.rz) $error("r_z expected %h actual %h", e.rz, r_z);
          if (magnitude !== e.mag)
            $error("magnitude expected %h actual %h", e.mag, magnitude);
          if (overflow !== e.ov)
            $error("overflow expected %b actual %b", e.ov, overflow);
          if (r_x !== e.rx || r_y !== e.ry || r_z !== e.rz || magnitude !== e.mag ||
              overflow !== e.ov)
            fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

@@ tb/tb_top.sv @@
// top of the 3d vector alu testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import v3alu_pkg::*;

  localparam int RANDOM_ITEMS = 1130;
  localparam int STALL_LIMIT  = 2000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, overflow;
  logic [2:0] mode;
  logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, factor, r_x, r_y, r_z;
  logic [31:0] magnitude;
  int fail_count, pending, idle_cycles;
  bit quiet_phase, hold_sink;

  vector3_alu DUT (.*);

  vector3_alu_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] pick_word(input int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      4: return $urandom_range(0, 32'h7ff) << $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [31:0] ax, ay, az, bx, by,
                           bz, f);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    factor <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random;
    int k;
    k = $urandom_range(0, 9);
    send_item(3'($urandom), pick_word(k < 6 ? 3 + k % 3 : $urandom_range(0, 5)),
              pick_word(k < 6 ? 3 + k % 3 : $urandom_range(0, 5)),
              pick_word(k < 6 ? 3 + k % 3 : $urandom_range(0, 5)),
              pick_word(k < 6 ? 3 + k % 3 : $urandom_range(0, 5)),
              pick_word(k < 6 ? 3 + k % 3 : $urandom_range(0, 5)),
              pick_word(k < 6 ? 3 + k % 3 : $urandom_range(0, 5)),
              pick_word(k < 6 ? 3 + k % 3 : $urandom_range(0, 5)));
  endtask

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [31:0] ext [5];
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_ADD;
    {a_x, a_y, a_z, b_x, b_y, b_z, factor} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h00010000};
    // every mode with extreme operands, zero vectors included
    for (int op = 0; op < 8; op++) begin
      send_item(3'(op), ext[0], ext[1], ext[3], ext[1], ext[0], ext[4], ext[1]);
      send_item(3'(op), ext[2], ext[2], ext[2], ext[2], ext[2], ext[2], ext[2]);
    end
    send_item(MODE_NORM, 32'h00030000, 32'hfffc0000, 0, 0, 0, 0, 0);
    send_item(MODE_NORM, ext[1], ext[1], ext[1], 0, 0, 0, 0);
    send_item(MODE_LEN, ext[1], ext[1], ext[1], 0, 0, 0, 0);
    send_item(MODE_DIST, ext[1], ext[1], ext[1], ext[0], ext[0], ext[0], 0);
    send_item(MODE_SCALE, ext[1], ext[0], ext[4], 0, 0, 0, ext[1]);
    send_item(MODE_CROSS, ext[1], ext[1], ext[0], ext[0], ext[1], ext[1], 0);
    hold_sink = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - 150) quiet_phase = 1;
      send_random();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
